// ----- design/esp_pkg.sv -----
// Shared types and constants for the printer escape sequence parser.
// No dependencies; used by every module of the block.
package esp_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int PAGE_WIDTH   = 16;

  localparam logic [7:0]  ESC_BYTE   = 8'h1B;
  localparam logic [30:0] EXIT_VALUE = 31'd12345;
  localparam logic [30:0] MAG_MAX    = 31'h7FFF_FFFF;

  // token kinds
  localparam logic [2:0] TK_STRAY   = 3'd0;
  localparam logic [2:0] TK_ESCAPE  = 3'd1;
  localparam logic [2:0] TK_COMMAND = 3'd2;
  localparam logic [2:0] TK_PAYLOAD = 3'd3;
  localparam logic [2:0] TK_EXIT    = 3'd4;
  localparam logic [2:0] TK_ERROR   = 3'd5;

  // payload kinds
  localparam logic [1:0] PK_NONE   = 2'd0;
  localparam logic [1:0] PK_IMAGE  = 2'd1;
  localparam logic [1:0] PK_HEADER = 2'd2;
  localparam logic [1:0] PK_COLOR  = 2'd3;

  typedef struct packed {
    logic [2:0]         token_kind;
    logic [7:0]         byte_value;
    logic [7:0]         intro_char;
    logic [7:0]         group_char;
    logic [7:0]         terminator_char;
    logic signed [31:0] param_value;
    logic               value_given;
    logic [1:0]         payload_kind;
    logic               payload_last;
    logic [15:0]        page_number;
    logic [2:0]         plane_color;
  } token_t;

endpackage

// ----- design/esp_parser.sv -----
// Parse state, parameter accumulation and page/plane tracking.
// One byte per step; token built combinationally. Depends on esp_pkg.
module esp_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output logic          has_result,
  output esp_pkg::token_t token
);
  import esp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ESC   = 3'd1;
  localparam logic [2:0] ST_INTRO = 3'd2;
  localparam logic [2:0] ST_VALUE = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;

  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_U       = 8'h55;
  localparam logic [7:0] CH_W       = 8'h57;
  localparam logic [7:0] CH_V       = 8'h56;
  localparam logic [7:0] CH_LC_R    = 8'h72;
  localparam logic [7:0] CH_LC_B    = 8'h62;
  localparam logic [7:0] CH_LC_G    = 8'h67;

  logic [2:0]            parse_state, parse_state_next;
  logic [7:0]            intro_reg, intro_reg_next;
  logic [7:0]            group_reg, group_reg_next;
  logic [30:0]           magnitude, magnitude_next;
  logic                  negative_flag, negative_flag_next;
  logic                  digits_seen, digits_seen_next;
  logic [30:0]           bytes_remaining, bytes_remaining_next;
  logic [1:0]            current_payload_kind, current_payload_kind_next;
  logic [PAGE_WIDTH-1:0] page_counter, page_counter_next;
  logic [2:0]            plane_counter, plane_counter_next;
  logic [2:0]            planes_per_page, planes_per_page_next;

  logic        is_cap;
  logic        is_digit;
  logic [34:0] mag_times10;
  logic [31:0] param_signed;
  logic        positive;
  logic [1:0]  start_kind;
  logic [30:0] start_len;

  assign is_cap   = (byte_in >= CH_A) && (byte_in <= CH_Z);
  assign is_digit = (byte_in >= CH_0) && (byte_in <= CH_9);
  // m*10 + d as shift-adds
  assign mag_times10 = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0}
                       + {31'd0, 4'(byte_in - CH_0)};
  assign param_signed = negative_flag ? (32'd0 - {1'b0, magnitude}) : {1'b0, magnitude};
  assign positive     = !negative_flag && (magnitude != '0);

  always_comb begin
    parse_state_next          = parse_state;
    intro_reg_next            = intro_reg;
    group_reg_next            = group_reg;
    magnitude_next            = magnitude;
    negative_flag_next        = negative_flag;
    digits_seen_next          = digits_seen;
    bytes_remaining_next      = bytes_remaining;
    current_payload_kind_next = current_payload_kind;
    page_counter_next         = page_counter;
    plane_counter_next        = plane_counter;
    planes_per_page_next      = planes_per_page;
    has_result                = 1'b0;
    token                     = '0;
    start_kind                = PK_NONE;
    start_len                 = magnitude;

    unique case (parse_state)
      ST_ESC: begin
        if (is_cap) begin
          parse_state_next = ST_IDLE;
          has_result       = 1'b1;
          token.token_kind = TK_ESCAPE;
          token.byte_value = byte_in;
        end else begin
          intro_reg_next   = byte_in;
          parse_state_next = ST_INTRO;
        end
      end
      ST_INTRO: begin
        if (is_cap) begin
          parse_state_next = ST_IDLE;
          has_result       = 1'b1;
          token.token_kind = TK_ERROR;
          token.byte_value = byte_in;
        end else begin
          group_reg_next     = byte_in;
          magnitude_next     = '0;
          negative_flag_next = 1'b0;
          digits_seen_next   = 1'b0;
          parse_state_next   = ST_VALUE;
        end
      end
      ST_VALUE: begin
        if (is_digit) begin
          magnitude_next   = (mag_times10 > {4'd0, MAG_MAX}) ? MAG_MAX
                                                               : mag_times10[30:0];
          digits_seen_next = 1'b1;
        end else if (byte_in == CH_MINUS) begin
          negative_flag_next = 1'b1;
        end else if (byte_in == CH_PLUS) begin
          negative_flag_next = 1'b0;
        end else if (!is_cap) begin
          parse_state_next = ST_IDLE;
          has_result       = 1'b1;
          token.token_kind = TK_ERROR;
          token.byte_value = byte_in;
        end else begin
          parse_state_next = ST_IDLE;
          has_result       = 1'b1;
          token.token_kind = TK_COMMAND;
          if (intro_reg == CH_PERCENT && byte_in == CH_X && !negative_flag &&
              magnitude == EXIT_VALUE) begin
            token.token_kind = TK_EXIT;
          end else if (intro_reg == CH_STAR && group_reg == CH_LC_R && byte_in == CH_U) begin
            planes_per_page_next = param_signed[2:0];
          end else if (intro_reg == CH_STAR && group_reg == CH_LC_R && byte_in == CH_A) begin
            page_counter_next  = page_counter + PAGE_WIDTH'(1);
            plane_counter_next = '0;
          end else if (intro_reg == CH_STAR && group_reg == CH_LC_B && byte_in == CH_W) begin
            if (positive) start_kind = PK_IMAGE;
          end else if (intro_reg == CH_STAR && group_reg == CH_LC_G && byte_in == CH_W) begin
            if (positive) start_kind = PK_COLOR;
          end else if (intro_reg == CH_STAR && group_reg == CH_LC_B && byte_in == CH_V) begin
            if (!negative_flag && magnitude == 31'(HEADER_BYTES)) begin
              if (plane_counter != 3'd7) plane_counter_next = plane_counter + 3'd1;
              start_kind = PK_HEADER;
              start_len  = 31'(HEADER_BYTES);
            end else if (positive) begin
              start_kind = PK_IMAGE;
            end
          end
          if (start_kind != PK_NONE) begin
            current_payload_kind_next = start_kind;
            bytes_remaining_next      = start_len;
            parse_state_next          = ST_DATA;
          end
          token.intro_char      = intro_reg;
          token.group_char      = group_reg;
          token.terminator_char = byte_in;
          token.param_value     = param_signed;
          token.value_given     = digits_seen;
          token.payload_kind    = start_kind;
        end
      end
      ST_DATA: begin
        has_result         = 1'b1;
        token.token_kind   = TK_PAYLOAD;
        token.byte_value   = byte_in;
        token.payload_kind = current_payload_kind;
        if (bytes_remaining <= 31'd1) begin
          token.payload_last   = 1'b1;
          bytes_remaining_next = '0;
          parse_state_next     = ST_IDLE;
        end else begin
          bytes_remaining_next = bytes_remaining - 31'd1;
        end
      end
      default: begin // idle, and any unused code
        if (byte_in == ESC_BYTE) begin
          parse_state_next = ST_ESC;
        end else begin
          parse_state_next = ST_IDLE;
          has_result       = 1'b1;
          token.token_kind = TK_STRAY;
          token.byte_value = byte_in;
        end
      end
    endcase

    // status fields reflect state after this byte
    token.page_number = 16'(page_counter_next);
    if (planes_per_page_next == 3'd4 && plane_counter_next >= 3'd1 &&
        plane_counter_next <= 3'd4) begin
      token.plane_color = plane_counter_next - 3'd1;
    end else if (planes_per_page_next == 3'd1) begin
      token.plane_color = 3'd3;
    end else begin
      token.plane_color = 3'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state          <= ST_IDLE;
      intro_reg            <= '0;
      group_reg            <= '0;
      magnitude            <= '0;
      negative_flag        <= 1'b0;
      digits_seen          <= 1'b0;
      bytes_remaining      <= '0;
      current_payload_kind <= PK_NONE;
      page_counter         <= '0;
      plane_counter        <= '0;
      planes_per_page      <= '0;
    end else if (step) begin
      parse_state          <= parse_state_next;
      intro_reg            <= intro_reg_next;
      group_reg            <= group_reg_next;
      magnitude            <= magnitude_next;
      negative_flag        <= negative_flag_next;
      digits_seen          <= digits_seen_next;
      bytes_remaining      <= bytes_remaining_next;
      current_payload_kind <= current_payload_kind_next;
      page_counter         <= page_counter_next;
      plane_counter        <= plane_counter_next;
      planes_per_page      <= planes_per_page_next;
    end
  end

endmodule

// ----- design/esp_token_reg.sv -----
// Output register for tokens with valid/ready handshake.
// Depends on esp_pkg for the token struct.
module esp_token_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  esp_pkg::token_t token_in,
  input  logic            out_ready,
  output logic            out_valid,
  output esp_pkg::token_t token_q
);
  import esp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_q <= token_in;
    end
  end

endmodule

// ----- design/printer_escape_sequence_parser_top.sv -----
// Top level of the printer escape sequence parser.
// Depends on esp_pkg, esp_parser and esp_token_reg.
//
// Byte-stream parser for printer escape sequences: ESC plus a capital, or
// ESC, intro, group, optional sign, digits and a capital terminator. Each
// finished command, stray byte or syntax error leaves as one token; image
// data (*b#W, *b#V), the plane header (*b20V) and colour blocks (*g#W) pass
// their bytes through as payload tokens, last one flagged. Bytes that only
// advance the parse (ESC, intro, group, digits, sign) produce no token.
// Throughput is one byte per clock while tokens are drained: an input
// register holds the byte, the parser updates combinationally, and a
// token register sits on the output, so a token passes through the input
// register and then the token register; a stalled output holds it back.
// The input register keeps taking bytes while a token waits in the output
// register, as long as those bytes produce no token themselves.
module printer_escape_sequence_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         token_kind,
  output logic [7:0]         byte_value,
  output logic [7:0]         intro_char,
  output logic [7:0]         group_char,
  output logic [7:0]         terminator_char,
  output logic signed [31:0] param_value,
  output logic               value_given,
  output logic [1:0]         payload_kind,
  output logic               payload_last,
  output logic [15:0]        page_number,
  output logic [2:0]         plane_color
);
  import esp_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  logic   step_fire;
  logic   has_result;
  logic   out_room;
  token_t token_next;
  token_t token_q;

  // output can take a token this cycle if empty or being drained
  assign out_room  = !out_valid || out_ready;
  // a byte that makes no token never waits on the output side
  assign step_fire = in_full && (!has_result || out_room);
  assign in_ready  = !in_full || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= byte_in;
    end
  end

  esp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step_fire),
    .byte_in    (in_byte),
    .has_result (has_result),
    .token      (token_next)
  );

  esp_token_reg u_token_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step_fire && has_result),
    .token_in  (token_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .token_q   (token_q)
  );

  assign token_kind      = token_q.token_kind;
  assign byte_value      = token_q.byte_value;
  assign intro_char      = token_q.intro_char;
  assign group_char      = token_q.group_char;
  assign terminator_char = token_q.terminator_char;
  assign param_value     = token_q.param_value;
  assign value_given     = token_q.value_given;
  assign payload_kind    = token_q.payload_kind;
  assign payload_last    = token_q.payload_last;
  assign page_number     = token_q.page_number;
  assign plane_color     = token_q.plane_color;

  // a token is only produced when the output register has room
  assert property (@(posedge clk) disable iff (rst)
    step_fire && has_result |-> out_room)
    else $error("token produced with no room in output register");

  // a held byte that is not consumed stays put
  assert property (@(posedge clk) disable iff (rst)
    in_full && !step_fire |=> in_full && $stable(in_byte))
    else $error("held input byte lost or changed");

  // payload bytes always carry a block kind
  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_PAYLOAD |-> payload_kind != PK_NONE)
    else $error("payload token without payload kind");

  // only command and payload tokens carry a payload kind
  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != TK_COMMAND && token_kind != TK_PAYLOAD
      |-> payload_kind == PK_NONE && !payload_last)
    else $error("payload fields set on a non-payload token");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for printer_escape_sequence_parser_top.
// Depends on esp_pkg and the parser RTL; holds its own token predictor and
// scoreboard, drives bytes over valid/ready and checks every token by field.
`timescale 1ns / 1ps

package esp_tb_pkg;
  import esp_pkg::*;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_Z     = "Z";
  localparam logic [7:0] CH_U     = "U";
  localparam logic [7:0] CH_V     = "V";
  localparam logic [7:0] CH_W     = "W";
  localparam logic [7:0] CH_X     = "X";
  localparam logic [7:0] CH_b     = "b";
  localparam logic [7:0] CH_g     = "g";
  localparam logic [7:0] CH_r     = "r";
  localparam logic [7:0] NO_SIGN  = 8'h00;

  typedef enum logic [2:0] {P_IDLE, P_ESC, P_INTRO, P_VALUE, P_DATA} parse_phase_t;

  // Token predictor plus the queue of tokens still owed by the block.
  class token_board;
    parse_phase_t phase      = P_IDLE;
    logic [7:0]   intro_r    = '0;
    logic [7:0]   group_r    = '0;
    logic [30:0]  mag        = '0;
    logic         neg        = 1'b0;
    logic         digit_seen = 1'b0;
    logic [30:0]  remaining  = '0;
    logic [1:0]   block_kind = PK_NONE;
    logic [15:0]  page_r     = '0;
    logic [2:0]   plane_idx  = '0;
    logic [2:0]   planes     = '0;

    token_t expected_tokens[$];
    int     mismatch_count = 0;
    int     token_count    = 0;

    static function bit is_capital(logic [7:0] c);
      return c >= CH_A && c <= CH_Z;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // page and colour reflect the state after the byte is taken
    function void push_token(logic [2:0] kind, logic [7:0] b, logic [7:0] it,
                             logic [7:0] gr, logic [7:0] tm, logic signed [31:0] pv,
                             logic vg, logic [1:0] pk, logic lst);
      token_t t;
      t.token_kind      = kind;
      t.byte_value      = b;
      t.intro_char      = it;
      t.group_char      = gr;
      t.terminator_char = tm;
      t.param_value     = pv;
      t.value_given     = vg;
      t.payload_kind    = pk;
      t.payload_last    = lst;
      t.page_number     = page_r;
      if (planes == 3'd4 && plane_idx >= 3'd1 && plane_idx <= 3'd4)
        t.plane_color = plane_idx - 3'd1;
      else if (planes == 3'd1)
        t.plane_color = 3'd3;
      else
        t.plane_color = 3'd4;
      expected_tokens.push_back(t);
    endfunction

    function void note_byte(logic [7:0] c);
      logic [63:0]        wide;
      logic signed [31:0] pv;
      logic [1:0]         start;
      logic [2:0]         kind;
      logic               positive;
      logic               is_last;
      case (phase)
        P_ESC: begin
          if (is_capital(c)) begin
            phase = P_IDLE;
            push_token(TK_ESCAPE, c, 0, 0, 0, 0, 0, PK_NONE, 0);
          end else begin
            intro_r = c;
            phase   = P_INTRO;
          end
        end
        P_INTRO: begin
          if (is_capital(c)) begin
            phase = P_IDLE;
            push_token(TK_ERROR, c, 0, 0, 0, 0, 0, PK_NONE, 0);
          end else begin
            group_r    = c;
            mag        = '0;
            neg        = 1'b0;
            digit_seen = 1'b0;
            phase      = P_VALUE;
          end
        end
        P_VALUE: begin
          if (c >= CH_0 && c <= CH_9) begin
            wide = {33'd0, mag} * 64'd10 + {56'd0, c - CH_0};
            mag  = (wide > {33'd0, MAG_MAX}) ? MAG_MAX : wide[30:0];
            digit_seen = 1'b1;
          end else if (c == CH_MINUS) begin
            neg = 1'b1;
          end else if (c == CH_PLUS) begin
            neg = 1'b0;
          end else begin
            phase = P_IDLE;
            if (!is_capital(c)) begin
              push_token(TK_ERROR, c, 0, 0, 0, 0, 0, PK_NONE, 0);
            end else begin
              pv       = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
              positive = !neg && mag != '0;
              kind     = TK_COMMAND;
              start    = PK_NONE;
              if (intro_r == CH_PCT && c == CH_X && !neg && mag == EXIT_VALUE) begin
                kind = TK_EXIT;
              end else if (intro_r == CH_STAR && group_r == CH_r && c == CH_U) begin
                planes = pv[2:0];
              end else if (intro_r == CH_STAR && group_r == CH_r && c == CH_A) begin
                page_r    = page_r + 16'd1;
                plane_idx = '0;
              end else if (intro_r == CH_STAR && group_r == CH_b && c == CH_W) begin
                if (positive) start = PK_IMAGE;
              end else if (intro_r == CH_STAR && group_r == CH_g && c == CH_W) begin
                if (positive) start = PK_COLOR;
              end else if (intro_r == CH_STAR && group_r == CH_b && c == CH_V) begin
                if (!neg && mag == 31'(HEADER_BYTES)) begin
                  if (plane_idx < 3'd7) plane_idx = plane_idx + 3'd1;
                  start = PK_HEADER;
                end else if (positive) begin
                  start = PK_IMAGE;
                end
              end
              // header length equals mag here, so one load covers all kinds
              if (start != PK_NONE) begin
                block_kind = start;
                remaining  = mag;
                phase      = P_DATA;
              end
              push_token(kind, 0, intro_r, group_r, c, pv, digit_seen, start, 0);
            end
          end
        end
        P_DATA: begin
          is_last = remaining <= 31'd1;
          if (is_last) begin
            remaining = '0;
            phase     = P_IDLE;
          end else begin
            remaining = remaining - 31'd1;
          end
          push_token(TK_PAYLOAD, c, 0, 0, 0, 0, 0, block_kind, is_last);
        end
        default: begin
          phase = P_IDLE;
          if (c == ESC_BYTE)
            phase = P_ESC;
          else
            push_token(TK_STRAY, c, 0, 0, 0, 0, 0, PK_NONE, 0);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("MISMATCH token %0d %s: got %0h want %0h", token_count, what, got_v,
                 want_v);
    endtask

    task check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch("token with nothing owed, kind", got.token_kind, 0);
      end else begin
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind)
          report_mismatch("token_kind", got.token_kind, want.token_kind);
        if (got.byte_value !== want.byte_value)
          report_mismatch("byte_value", got.byte_value, want.byte_value);
        if (got.intro_char !== want.intro_char)
          report_mismatch("intro_char", got.intro_char, want.intro_char);
        if (got.group_char !== want.group_char)
          report_mismatch("group_char", got.group_char, want.group_char);
        if (got.terminator_char !== want.terminator_char)
          report_mismatch("terminator_char", got.terminator_char, want.terminator_char);
        if (got.param_value !== want.param_value)
          report_mismatch("param_value", got.param_value, want.param_value);
        if (got.value_given !== want.value_given)
          report_mismatch("value_given", got.value_given, want.value_given);
        if (got.payload_kind !== want.payload_kind)
          report_mismatch("payload_kind", got.payload_kind, want.payload_kind);
        if (got.payload_last !== want.payload_last)
          report_mismatch("payload_last", got.payload_last, want.payload_last);
        if (got.page_number !== want.page_number)
          report_mismatch("page_number", got.page_number, want.page_number);
        if (got.plane_color !== want.plane_color)
          report_mismatch("plane_color", got.plane_color, want.plane_color);
      end
      token_count++;
    endtask
  endclass

endpackage

module tb_top;
  import esp_pkg::*;
  import esp_tb_pkg::*;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         byte_in  = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         token_kind;
  logic [7:0]         byte_value;
  logic [7:0]         intro_char;
  logic [7:0]         group_char;
  logic [7:0]         terminator_char;
  logic signed [31:0] param_value;
  logic               value_given;
  logic [1:0]         payload_kind;
  logic               payload_last;
  logic [15:0]        page_number;
  logic [2:0]         plane_color;

  token_board board = new;

  int bytes_sent = 0;
  bit in_calm    = 1'b0;   // stretch with no input gaps
  bit out_calm   = 1'b0;   // stretch with no output stalls
  int stall_left = 0;

  printer_escape_sequence_parser_top uut (.*);

  always #10 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Both handshakes are sampled on pre-edge values. The output side is checked
  // before the input side is noted, so a token can never be matched against
  // the byte accepted on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_token(token_t'{token_kind, byte_value, intro_char, group_char,
                                   terminator_char, param_value, value_given,
                                   payload_kind, payload_last, page_number,
                                   plane_color});
      if (in_valid && in_ready)
        board.note_byte(byte_in);
    end
  end

  // Token sink: random back-pressure with calm stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left <= pick_gap(out_calm);
    end
    if ($urandom_range(0, 399) == 0) out_calm <= !out_calm;
  end

  // One item: optional idle gap, then hold valid and the byte until taken.
  // Valid is only dropped when a gap follows, never in the acceptance step
  // of a back-to-back item.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_escape(input string body);
    send_byte(ESC_BYTE);
    send_text(body);
  endtask

  // Payload bytes, with ESC mixed in since it is plain data there.
  task automatic send_payload(input int n);
    repeat (n) send_byte(($urandom_range(0, 6) == 0) ? ESC_BYTE : 8'($urandom_range(0, 255)));
  endtask

  // ESC intro group [sign] [digits] term, followed by the block it opens.
  // value < 0 means no digits at all. Callers keep payload values small.
  task automatic send_command(input logic [7:0] intro, input logic [7:0] grp,
                              input logic [7:0] sgn, input int value,
                              input logic [7:0] term);
    int len;
    send_byte(ESC_BYTE);
    send_byte(intro);
    send_byte(grp);
    if (sgn != NO_SIGN) send_byte(sgn);
    if (value >= 0) begin
      if ($urandom_range(0, 4) == 0) send_byte(CH_0);
      send_text($sformatf("%0d", value));
    end
    send_byte(term);
    len = 0;
    // *b20V opens a header of exactly its own value, so one rule fits all
    if (intro == CH_STAR && sgn != CH_MINUS && value > 0 &&
        ((term == CH_W && (grp == CH_b || grp == CH_g)) ||
         (term == CH_V && grp == CH_b)))
      len = value;
    send_payload(len);
  endtask

  function automatic logic [7:0] any_noncapital();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (token_board::is_capital(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_sign();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return NO_SIGN;
    if (r < 8) return CH_PLUS;
    return CH_MINUS;
  endfunction

  // Block lengths stay small; zero and "no digits" show up now and then.
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return -1;
    if (r == 1) return 0;
    return $urandom_range(1, 24);
  endfunction

  // Truncated or malformed sequences ending in a syntax error.
  task automatic send_broken();
    logic [7:0] bad;
    send_byte(ESC_BYTE);
    send_byte(any_noncapital());
    if ($urandom_range(0, 1) == 0) begin
      send_byte(8'(CH_A + $urandom_range(0, 25)));
    end else begin
      send_byte(any_noncapital());
      repeat ($urandom_range(0, 3)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
      do bad = 8'($urandom_range(0, 255));
      while (token_board::is_capital(bad) || (bad >= CH_0 && bad <= CH_9) ||
             bad == CH_PLUS || bad == CH_MINUS);
      send_byte(bad);
    end
  endtask

  // Arbitrary parameterized command that never opens a payload block: long
  // digit runs (saturation) and signs sprinkled anywhere in the value.
  task automatic send_any_command();
    logic [7:0] intro;
    logic [7:0] grp;
    logic [7:0] term;
    case ($urandom_range(0, 4))
      0:       intro = CH_STAR;
      1:       intro = CH_PCT;
      2:       intro = "&";
      3:       intro = "(";
      default: intro = any_noncapital();
    endcase
    case ($urandom_range(0, 4))
      0:       grp = CH_b;
      1:       grp = CH_g;
      2:       grp = CH_r;
      3:       grp = "l";
      default: grp = any_noncapital();
    endcase
    term = 8'(CH_A + $urandom_range(0, 25));
    if (intro == CH_STAR && (grp == CH_b || grp == CH_g) && (term == CH_W || term == CH_V))
      term = CH_A;
    send_byte(ESC_BYTE);
    send_byte(intro);
    send_byte(grp);
    repeat ($urandom_range(0, 13)) begin
      if ($urandom_range(0, 6) == 0)
        send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      else
        send_byte(8'(CH_0 + $urandom_range(0, 9)));
    end
    send_byte(term);
  endtask

  // Commands the block acts on: blocks, page and plane tracking, exit.
  task automatic send_known_command();
    case ($urandom_range(0, 7))
      0: send_command(CH_STAR, CH_b, rand_sign(), rand_len(), CH_W);
      1: send_command(CH_STAR, CH_b, rand_sign(), rand_len(), CH_V);
      2, 3: send_command(CH_STAR, CH_b, $urandom_range(0, 3) ? NO_SIGN : CH_PLUS,
                         HEADER_BYTES, CH_V);
      4: send_command(CH_STAR, CH_g, rand_sign(), rand_len(), CH_W);
      5: send_command(CH_STAR, CH_r, NO_SIGN, $urandom_range(0, 2) - 1, CH_A);
      6: begin
        case ($urandom_range(0, 3))
          0:       send_command(CH_STAR, CH_r, NO_SIGN, 1, CH_U);
          1:       send_command(CH_STAR, CH_r, NO_SIGN, 4, CH_U);
          default: send_command(CH_STAR, CH_r, rand_sign(), $urandom_range(0, 15), CH_U);
        endcase
      end
      default: begin
        // exit, or near misses on sign, value and terminator
        case ($urandom_range(0, 3))
          0:       send_command(CH_PCT, CH_MINUS, NO_SIGN, 12345, CH_X);
          1:       send_command(CH_PCT, any_noncapital(), rand_sign(), 12345, CH_X);
          2:       send_command(CH_PCT, CH_MINUS, NO_SIGN, 12344 + $urandom_range(0, 2),
                                CH_X);
          default: send_command(CH_PCT, CH_MINUS, NO_SIGN, 12345, CH_Z);
        endcase
      end
    endcase
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    send_byte(8'h00);                                     // strays at both ends
    send_byte(8'hFF);
    send_escape("E");                                     // two-char escapes
    send_escape("Z");
    send_escape("*A");                                    // capital right after intro
    send_escape("*r1x");                                  // bad byte in the value
    send_escape("*r5");                                   // ESC as the bad byte
    send_byte(ESC_BYTE);
    send_command(CH_PCT, CH_MINUS, NO_SIGN, 12345, CH_X); // language exit
    send_command(CH_PCT, "@", CH_MINUS, 12345, CH_X);     // negative: plain command
    send_command(CH_STAR, CH_r, NO_SIGN, 4, CH_U);        // four planes per page
    send_command(CH_STAR, CH_r, NO_SIGN, -1, CH_A);       // new page, no digits
    repeat (8) send_command(CH_STAR, CH_b, NO_SIGN, HEADER_BYTES, CH_V); // plane count tops out
    send_command(CH_STAR, CH_b, NO_SIGN, 3, CH_W);        // image block
    send_command(CH_STAR, CH_b, NO_SIGN, 1, CH_W);        // one-byte block
    send_command(CH_STAR, CH_b, NO_SIGN, 0, CH_W);        // zero length: no block
    send_command(CH_STAR, CH_b, CH_MINUS, 5, CH_W);       // negative length: no block
    send_command(CH_STAR, CH_b, NO_SIGN, 7, CH_V);        // image via V
    send_command(CH_STAR, CH_b, CH_MINUS, HEADER_BYTES, CH_V);
    send_command(CH_STAR, CH_g, CH_PLUS, 4, CH_W);        // colour block
    send_escape("*r99999999999U");                        // magnitude saturates
    send_escape("*r-99999999999U");
    send_escape("*r-+7U");                                // later sign wins
    send_command(CH_STAR, CH_r, CH_MINUS, 3, CH_U);       // low bits of negative value
    send_command(CH_STAR, CH_r, NO_SIGN, 1, CH_U);        // single plane: black

    // --- random ---
    while (bytes_sent < 1600) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      if (pick < 12) begin
        repeat ($urandom_range(1, 4)) begin
          logic [7:0] b;
          do b = 8'($urandom_range(0, 255)); while (b == ESC_BYTE);
          send_byte(b);
        end
      end else if (pick < 20) begin
        send_byte(ESC_BYTE);
        send_byte(8'(CH_A + $urandom_range(0, 25)));
      end else if (pick < 28) begin
        send_broken();
      end else if (pick < 42) begin
        send_any_command();
      end else begin
        send_known_command();
      end
    end
    in_valid <= 1'b0;

    // let the monitor see the last acceptance, then drain with some slack
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/esp_pkg.sv
design/esp_parser.sv
design/esp_token_reg.sv
design/printer_escape_sequence_parser_top.sv
verif/tb_top.sv
